/* rtl/bag_pkg.sv */
// Package for the broadcast address generator: sizes, codes, link and config structs.
`timescale 1ns / 1ps

package bag_pkg;

    // Block geometry.
    localparam int MAX_RANK   = 4;
    localparam int DIM_BITS   = 16;
    localparam int ADDR_BITS  = 32;
    localparam int OFS_BITS   = 32;
    localparam int RANK_BITS  = 3;
    localparam int EB_BITS    = 4;
    localparam int STAT_BITS  = 3;
    localparam int IDX_BITS   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int DIMS_BITS  = MAX_RANK * DIM_BITS;
    localparam int CFG_BITS   = DIMS_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int TOT_BITS   = ADDR_BITS + 1;
    localparam int PROD_BITS  = TOT_BITS + DIM_BITS;
    localparam int IN_BITS    = 8;
    localparam int OUT_BITS   = 2 * OFS_BITS;

    // Largest legal target size in bytes.
    localparam logic [TOT_BITS-1:0] ADDR_LIMIT = TOT_BITS'(1) << ADDR_BITS;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_RANK = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_RANK = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_DIMS = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_DIMS = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELEM_BYTES  = CFG_IDX_BITS'(4);

    // Status codes.
    localparam logic [STAT_BITS-1:0] ST_OK       = STAT_BITS'(0);
    localparam logic [STAT_BITS-1:0] ST_RANK     = STAT_BITS'(1);
    localparam logic [STAT_BITS-1:0] ST_SHAPE    = STAT_BITS'(2);
    localparam logic [STAT_BITS-1:0] ST_EMPTY    = STAT_BITS'(3);
    localparam logic [STAT_BITS-1:0] ST_OVERFLOW = STAT_BITS'(4);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } t_state;

    // Token and partial results handed from one cell to the next.
    typedef struct packed {
        logic                 tok;
        logic                 restart;
        logic                 carry;
        logic                 notlast;
        logic [OFS_BITS-1:0]  sum;
        logic [OFS_BITS-1:0]  acc;
        logic [TOT_BITS-1:0]  total;
        logic                 ovf;
        logic                 mism;
        logic                 zero;
    } t_link;

    // Per-cell view of the live configuration.
    typedef struct packed {
        logic [DIM_BITS-1:0]  dim;
        logic [DIM_BITS-1:0]  src_dim;
        logic                 in_range;
        logic                 src_range;
    } t_cell_cfg;

    // Walk-wide configuration seen by the controller.
    typedef struct packed {
        logic [RANK_BITS-1:0] target_rank;
        logic [RANK_BITS-1:0] source_rank;
        logic [EB_BITS-1:0]   eb;
    } t_walk_cfg;

    // One result word.
    typedef struct packed {
        logic [OFS_BITS-1:0]  dst;
        logic [OFS_BITS-1:0]  src;
        logic                 last;
        logic [STAT_BITS-1:0] status;
    } t_result;

endpackage

/* rtl/bag_cell.sv */
// One dimension cell: holds its counter and stride and updates the passing token.
`timescale 1ns / 1ps

module bag_cell
    import bag_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cfg i_cfg,
    input  t_link     i_link,
    output t_link     o_link
);

    logic [DIM_BITS-1:0]  r_counter;
    logic [DIM_BITS-1:0]  n_counter;
    logic [OFS_BITS-1:0]  r_stride;
    logic [OFS_BITS-1:0]  n_stride;
    t_link                r_link;
    t_link                n_link;

    logic [DIM_BITS-1:0]  w_t_eff;
    logic [DIM_BITS-1:0]  w_s_eff;
    logic [PROD_BITS-1:0] w_tot_prod;
    logic [DIM_BITS:0]    w_cnt_inc;
    logic [DIM_BITS:0]    w_cnt_next_inc;
    logic                 w_wrap;
    logic [OFS_BITS-1:0]  w_term;

    // Token update: a restart builds size and strides, an advance ripples the carry and sums the offset.
    always_comb begin
        n_link         = i_link;
        n_counter      = r_counter;
        n_stride       = r_stride;
        w_t_eff        = i_cfg.in_range ? i_cfg.dim : DIM_BITS'(1);
        w_s_eff        = i_cfg.src_range ? i_cfg.src_dim : DIM_BITS'(1);
        w_tot_prod     = PROD_BITS'(i_link.total) * PROD_BITS'(w_t_eff);
        w_cnt_inc      = {1'b0, r_counter} + (DIM_BITS + 1)'(1);
        w_wrap         = w_cnt_inc >= {1'b0, i_cfg.dim};
        w_cnt_next_inc = '0;
        w_term         = '0;
        if (i_link.tok) begin
            if (i_link.restart) begin
                n_counter    = '0;
                n_stride     = (i_cfg.src_range && (i_cfg.src_dim != DIM_BITS'(1)))
                               ? i_link.acc : '0;
                n_link.total = w_tot_prod[TOT_BITS-1:0];
                n_link.acc   = i_link.acc * OFS_BITS'(w_s_eff);
                n_link.ovf   = i_link.ovf
                               | (i_cfg.in_range && (w_tot_prod > PROD_BITS'(ADDR_LIMIT)));
                n_link.mism  = i_link.mism
                               | (i_cfg.src_range && (i_cfg.src_dim != DIM_BITS'(1))
                                  && (i_cfg.src_dim != i_cfg.dim));
                n_link.zero  = i_link.zero | (i_cfg.in_range && (i_cfg.dim == '0));
            end else begin
                if (i_cfg.in_range && i_link.carry) begin
                    n_counter    = w_wrap ? '0 : w_cnt_inc[DIM_BITS-1:0];
                    n_link.carry = w_wrap;
                end
                w_cnt_next_inc = {1'b0, n_counter} + (DIM_BITS + 1)'(1);
                w_term         = OFS_BITS'(n_counter) * r_stride;
                if (i_cfg.in_range) begin
                    n_link.sum     = i_link.sum + w_term;
                    n_link.notlast = i_link.notlast
                                     | (w_cnt_next_inc < {1'b0, i_cfg.dim});
                end
            end
        end
    end

    // Cell state and the link register toward the lower neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_stride  <= '0;
            r_link    <= '0;
        end else begin
            r_counter <= n_counter;
            r_stride  <= n_stride;
            r_link    <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

/* rtl/bag_ctrl.sv */
// Walk controller: launches tokens, forms status and offsets, holds the output word.
`timescale 1ns / 1ps

module bag_ctrl
    import bag_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_walk_cfg i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_restart,
    input  t_link     i_link,
    output t_link     o_seed,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_result   o_out
);

    t_state               r_state;
    t_state               n_state;
    t_link                r_seed;
    t_link                n_seed;
    logic                 r_walk_done;
    logic                 n_walk_done;
    logic [OFS_BITS-1:0]  r_dst_element;
    logic [OFS_BITS-1:0]  n_dst_element;
    t_result              r_res;
    t_result              n_res;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic                 w_rank_err;
    logic [STAT_BITS-1:0] w_status;
    logic [OFS_BITS-1:0]  w_dst_next;
    logic                 w_single;

    // Restart checks in priority order.
    always_comb begin
        w_rank_err = (i_cfg.target_rank > RANK_BITS'(MAX_RANK))
                     || (i_cfg.source_rank > i_cfg.target_rank);
        if (i_cfg.target_rank == '0) begin
            w_status = ST_EMPTY;
        end else if (w_rank_err) begin
            w_status = ST_RANK;
        end else if (i_link.mism) begin
            w_status = ST_SHAPE;
        end else if (i_link.zero) begin
            w_status = ST_EMPTY;
        end else if (i_link.ovf) begin
            w_status = ST_OVERFLOW;
        end else begin
            w_status = ST_OK;
        end
        w_dst_next = r_dst_element + OFS_BITS'(1);
        w_single   = i_link.total == TOT_BITS'(i_cfg.eb);
    end

    // Next state, token launch, result forming and output register control.
    always_comb begin
        n_state       = r_state;
        n_seed        = r_seed;
        n_seed.tok    = 1'b0;
        n_walk_done   = r_walk_done;
        n_dst_element = r_dst_element;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out         = r_out;
        o_in_ready    = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_restart && r_walk_done) begin
                        n_res   = '{dst: '0, src: '0, last: 1'b0, status: ST_EMPTY};
                        n_state = S_FINISH;
                    end else begin
                        n_seed         = '0;
                        n_seed.tok     = 1'b1;
                        n_seed.restart = i_restart;
                        n_seed.carry   = !i_restart;
                        n_seed.acc     = OFS_BITS'(1);
                        n_seed.total   = TOT_BITS'(i_cfg.eb);
                        n_state        = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (i_link.tok) begin
                    if (i_link.restart) begin
                        n_dst_element = '0;
                        if (w_status != ST_OK) begin
                            n_walk_done = 1'b1;
                            n_res = '{dst: '0, src: '0, last: 1'b0, status: w_status};
                        end else begin
                            n_walk_done = w_single;
                            n_res = '{dst: '0, src: '0, last: w_single, status: ST_OK};
                        end
                    end else begin
                        n_dst_element = w_dst_next;
                        n_walk_done   = !i_link.notlast;
                        n_res.dst     = w_dst_next * OFS_BITS'(i_cfg.eb);
                        n_res.src     = i_link.sum * OFS_BITS'(i_cfg.eb);
                        n_res.last    = !i_link.notlast;
                        n_res.status  = ST_OK;
                    end
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk state and output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed        <= '0;
            r_walk_done   <= 1'b1;
            r_dst_element <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_seed        <= n_seed;
            r_walk_done   <= n_walk_done;
            r_dst_element <= n_dst_element;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_seed      = r_seed;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/broadcast_address_generator_top.sv */
// Top level of the broadcast address generator: config registers, cell row, controller.
//
//  Channel  | Direction | Handshake                    | Contents
//  ---------+-----------+------------------------------+--------------------------------
//  cfg      | in        | i_cfg_we                     | i_cfg_idx, i_cfg_data
//  s_axis   | in        | s_axis_tvalid, s_axis_tready | tdata: restart
//  m_axis   | out       | m_axis_tvalid, m_axis_tready | tdata: dst, src; tlast; tuser: status
//
// Each word occupies the block from acceptance to the next ready: the token crosses
// the row of dimension cells one cell per cycle, then the controller forms the
// offsets and loads the output register. An advance after the walk has finished
// skips the cell row. A word is accepted while a finished result still waits.
// Synchronous active-low reset leaves the walk finished until the first restart.
// A stalled output holds its word and blocks only the final load of the next result.
`timescale 1ns / 1ps

module broadcast_address_generator_top
    import bag_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_BITS-1:0]      s_axis_tdata,   // [0] restart
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_BITS-1:0]     m_axis_tdata,   // [31:0] dst_offset, [63:32] src_offset
    output logic                    m_axis_tlast,
    output logic [STAT_BITS-1:0]    m_axis_tuser    // [2:0] status
);

    logic [RANK_BITS-1:0] r_target_rank;
    logic [RANK_BITS-1:0] r_source_rank;
    logic [DIMS_BITS-1:0] r_target_dims;
    logic [DIMS_BITS-1:0] r_source_dims;
    logic [EB_BITS-1:0]   r_elem_bytes;

    logic [RANK_BITS-1:0] w_off;
    t_cell_cfg            w_cell_cfg [MAX_RANK];
    t_link                w_link     [MAX_RANK+1];
    t_walk_cfg            w_walk_cfg;
    t_result              w_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_rank <= RANK_BITS'(1);
            r_source_rank <= '0;
            r_target_dims <= '0;
            r_source_dims <= '0;
            r_elem_bytes  <= EB_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_RANK: r_target_rank <= i_cfg_data[RANK_BITS-1:0];
                CFG_SOURCE_RANK: r_source_rank <= i_cfg_data[RANK_BITS-1:0];
                CFG_TARGET_DIMS: r_target_dims <= i_cfg_data[DIMS_BITS-1:0];
                CFG_SOURCE_DIMS: r_source_dims <= i_cfg_data[DIMS_BITS-1:0];
                CFG_ELEM_BYTES:  r_elem_bytes  <= i_cfg_data[EB_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Per-cell view: target size, aligned source size and range flags.
    always_comb begin
        w_off = r_target_rank - r_source_rank;
        for (int j = 0; j < MAX_RANK; j++) begin
            w_cell_cfg[j].dim       = r_target_dims[j*DIM_BITS +: DIM_BITS];
            w_cell_cfg[j].in_range  = RANK_BITS'(j) < r_target_rank;
            w_cell_cfg[j].src_range = (RANK_BITS'(j) < r_target_rank)
                                      && (RANK_BITS'(j) >= w_off);
            w_cell_cfg[j].src_dim   =
                r_source_dims[IDX_BITS'(RANK_BITS'(j) - w_off) * DIM_BITS +: DIM_BITS];
        end
    end

    // Walk-wide settings; an element size of zero counts as one byte.
    assign w_walk_cfg.target_rank = r_target_rank;
    assign w_walk_cfg.source_rank = r_source_rank;
    assign w_walk_cfg.eb          = (r_elem_bytes == '0) ? EB_BITS'(1) : r_elem_bytes;

    // Row of cells: the token enters at the highest dimension and leaves at dimension zero.
    for (genvar j = 0; j < MAX_RANK; j++) begin : g_cell
        bag_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (w_cell_cfg[j]),
            .i_link  (w_link[j+1]),
            .o_link  (w_link[j])
        );
    end

    bag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_walk_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_restart   (s_axis_tdata[0]),
        .i_link      (w_link[0]),
        .o_seed      (w_link[MAX_RANK]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    // Output word packing.
    assign m_axis_tdata = {w_out.src, w_out.dst};
    assign m_axis_tlast = w_out.last;
    assign m_axis_tuser = w_out.status;

endmodule

/* rtl/bag_checker.sv */
// Port-level checker for the broadcast address generator, bound to the top level.
`timescale 1ns / 1ps

module bag_checker
    import bag_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_BITS-1:0]  m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic [STAT_BITS-1:0] m_axis_tuser
);

    // A result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Only one word is in flight: an accepted word closes the input in the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a word is still at work");

    // An error or finished status carries zero offsets and no last mark.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("error status with nonzero offsets or last");

    // The last element is only ever marked on a good word.
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tuser == ST_OK))
        else $error("last marked on an error word");

endmodule

bind broadcast_address_generator_top bag_checker u_bag_checker (.*);
